// ===== hw/rtl/button_press_classifier_macros.svh =====
// Assertion macros for the button press classifier RTL, included by bpc_fifo.
// Expects a clock named clock and a synchronous reset named reset in scope.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Property checked on every clock edge outside reset
`define BPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in this cycle implies expectation in the next cycle
`define BPC_ASSERT_NEXT(label, cond, outcome, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (outcome)) \
      else $error(msg);

`endif

// ===== hw/rtl/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
// No dependencies; imported by every module of the block.
package bpc_pkg;

   localparam int NUM_BUTTONS = 3;
   localparam int MAX_RESULTS = 3;
   localparam int TIME_W      = 32;
   localparam int THRESH_W    = 16;
   localparam int CSR_INDEX_W = 2;

   // Result FIFO sizing
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS = 2'd1;

   // Reset values of the thresholds
   localparam logic [THRESH_W-1:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd1000;

   // Button codes
   localparam logic [1:0] CODE_UP     = 2'd0;
   localparam logic [1:0] CODE_DOWN   = 2'd1;
   localparam logic [1:0] CODE_CENTER = 2'd2;
   localparam logic [1:0] CODE_COMBO  = 2'd3;

   localparam logic [1:0] LANE_CODE [NUM_BUTTONS] = '{CODE_UP, CODE_DOWN, CODE_CENTER};

   // Lane indexes
   localparam int LANE_UP     = 0;
   localparam int LANE_DOWN   = 1;
   localparam int LANE_CENTER = 2;

   // Press kinds
   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   // What a tick does to the block state
   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ENTRY,
      MODE_HOLD,
      MODE_EXIT
   } tick_mode_type;

   // Per-button findings of one lane
   typedef struct packed {
      logic fall;
      logic fire;
      logic is_long;
   } lane_result_type;

   // One result entry
   typedef struct packed {
      logic [1:0] code;
      logic       kind;
      logic       last;
   } rsp_entry_type;

   // Merged result of one tick
   typedef struct packed {
      tick_mode_type                       mode;
      logic [1:0]                          count;
      rsp_entry_type [MAX_RESULTS-1:0]     slot;
   } merge_out_type;

endpackage

// ===== hw/rtl/button_press_classifier.sv =====
// Button press classifier: three lanes classify presses, results queue for output.
// An accepted tick's results are registered in the result queue and offered in order.
// Throughput: one tick per cycle while at least three result slots are free; results leave
// at one per cycle while rsp_stall is low, so ticks with several events drain at that rate.
// Reset: synchronous active high; levels released, press starts 0, thresholds 20 and 1000.
// Depends on bpc_pkg, bpc_lane, bpc_merge and bpc_fifo.
module button_press_classifier import bpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // scan tick requests
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_up_level,
   input  logic                   req_down_level,
   input  logic                   req_center_level,
   input  logic [TIME_W-1:0]      req_now_ms,
   // press events
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_button_code,
   output logic                   rsp_press_kind,
   output logic                   rsp_last_of_run,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THRESH_W-1:0]    csr_wdata
);

   logic [THRESH_W-1:0]  debounce_ff, debounce_in;
   logic [THRESH_W-1:0]  long_press_ff, long_press_in;
   logic [NUM_BUTTONS-1:0] prior_ff, prior_in;
   logic [TIME_W-1:0]    start_ff [NUM_BUTTONS];
   logic [TIME_W-1:0]    start_in [NUM_BUTTONS];
   logic                 combo_ff, combo_in;

   logic [NUM_BUTTONS-1:0]            lvl;
   lane_result_type [NUM_BUTTONS-1:0] lanes;
   merge_out_type                     merged;
   logic                              accept;
   logic                              fifo_room;
   rsp_entry_type                     head;

   assign lvl = {req_center_level, req_down_level, req_up_level};

   // handshakes
   assign req_stall = ~fifo_room;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // one lane per button
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      bpc_lane u_lane (
         .level         (lvl[i]),
         .prior         (prior_ff[i]),
         .start_ms      (start_ff[i]),
         .now_ms        (req_now_ms),
         .debounce_ms   (debounce_ff),
         .long_press_ms (long_press_ff),
         .result        (lanes[i])
      );
   end

   bpc_merge u_merge (
      .combo_active (combo_ff),
      .up_level     (req_up_level),
      .down_level   (req_down_level),
      .lanes        (lanes),
      .merged       (merged)
   );

   // threshold registers
   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE:   debounce_in   = csr_wdata;
            CSR_LONG_PRESS: long_press_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // button state update per accepted tick
   always_comb begin
      prior_in = prior_ff;
      start_in = start_ff;
      combo_in = combo_ff;
      if (accept) begin
         case (merged.mode)
            MODE_NORMAL: begin
               for (int i = 0; i < NUM_BUTTONS; i++) begin
                  if (lanes[i].fall) begin
                     start_in[i] = req_now_ms;
                  end
               end
               prior_in = lvl;
            end
            MODE_ENTRY: begin
               combo_in            = 1'b1;
               start_in[LANE_UP]   = '0;
               start_in[LANE_DOWN] = '0;
               prior_in            = lvl;
            end
            MODE_EXIT: begin
               combo_in              = 1'b0;
               prior_in[LANE_UP]     = 1'b1;
               prior_in[LANE_DOWN]   = 1'b1;
               prior_in[LANE_CENTER] = lvl[LANE_CENTER];
               start_in[LANE_UP]     = '0;
               start_in[LANE_DOWN]   = '0;
            end
            default: begin
               prior_in = lvl;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         prior_ff      <= '1;
         combo_ff      <= 1'b0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            start_ff[i] <= '0;
         end
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
         prior_ff      <= prior_in;
         combo_ff      <= combo_in;
         start_ff      <= start_in;
      end
   end

   // result queue
   bpc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (accept ? merged.count : 2'd0),
      .push_slot (merged.slot),
      .pop       (rsp_valid & ~rsp_stall),
      .head      (head),
      .not_empty (rsp_valid),
      .has_room  (fifo_room)
   );

   assign rsp_button_code = head.code;
   assign rsp_press_kind  = head.kind;
   assign rsp_last_of_run = head.last;

endmodule

// ===== hw/rtl/bpc_lane.sv =====
// One button lane: edge detection and hold time classification.
// Depends on bpc_pkg.
module bpc_lane import bpc_pkg::*; (
   input  logic                level,
   input  logic                prior,
   input  logic [TIME_W-1:0]   start_ms,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [THRESH_W-1:0] debounce_ms,
   input  logic [THRESH_W-1:0] long_press_ms,
   output lane_result_type     result
);

   logic [TIME_W-1:0] held;
   logic              rise;
   logic              over_long;
   logic              over_debounce;

   // held time wraps modulo 2^32
   assign held          = now_ms - start_ms;
   assign rise          = level & ~prior;
   assign over_long     = held >= {{(TIME_W-THRESH_W){1'b0}}, long_press_ms};
   assign over_debounce = held >= {{(TIME_W-THRESH_W){1'b0}}, debounce_ms};

   assign result.fall    = ~level & prior;
   assign result.fire    = rise & (over_long | over_debounce);
   assign result.is_long = over_long;

endmodule

// ===== hw/rtl/bpc_merge.sv =====
// Merge stage: picks the tick mode and packs lane events into result slots.
// Depends on bpc_pkg.
module bpc_merge import bpc_pkg::*; (
   input  logic                               combo_active,
   input  logic                               up_level,
   input  logic                               down_level,
   input  lane_result_type [NUM_BUTTONS-1:0]  lanes,
   output merge_out_type                      merged
);

   always_comb begin
      logic [1:0] idx;
      idx    = 2'd0;
      merged = '0;

      // mode of this tick
      if (combo_active) begin
         merged.mode = (up_level && down_level) ? MODE_EXIT : MODE_HOLD;
      end else if (!up_level && !down_level) begin
         merged.mode = MODE_ENTRY;
      end else begin
         merged.mode = MODE_NORMAL;
      end

      case (merged.mode)
         MODE_ENTRY: begin
            merged.count        = 2'd1;
            merged.slot[0].code = CODE_COMBO;
            merged.slot[0].kind = KIND_SHORT;
            merged.slot[0].last = 1'b1;
         end
         MODE_NORMAL: begin
            // compact fired lanes in order up, down, center
            for (int i = 0; i < NUM_BUTTONS; i++) begin
               if (lanes[i].fire) begin
                  merged.slot[idx].code = LANE_CODE[i];
                  merged.slot[idx].kind = lanes[i].is_long ? KIND_LONG : KIND_SHORT;
                  idx = idx + 2'd1;
               end
            end
            merged.count = idx;
            for (int k = 0; k < MAX_RESULTS; k++) begin
               merged.slot[k].last = (2'(k) == idx - 2'd1);
            end
         end
         default: begin
            merged.count = 2'd0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/bpc_fifo.sv =====
// Result FIFO: takes up to three results per cycle, hands out one.
// Depends on bpc_pkg and button_press_classifier_macros.svh.
`include "button_press_classifier_macros.svh"

module bpc_fifo import bpc_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       push_n,
   input  rsp_entry_type [MAX_RESULTS-1:0]  push_slot,
   input  logic                             pop,
   output rsp_entry_type                    head,
   output logic                             not_empty,
   output logic                             has_room
);

   rsp_entry_type    mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < push_n) begin
            mem_ff[wr_ptr_ff + PTR_W'(k)] <= push_slot[k];
         end
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));

   `BPC_ASSERT(a_count_bound, count_ff <= CNT_W'(FIFO_DEPTH), "fifo count above depth")
   `BPC_ASSERT(a_no_overflow, (push_n != 2'd0) |-> (count_in <= CNT_W'(FIFO_DEPTH)), "fifo push overflows")
   `BPC_ASSERT(a_no_underflow, pop |-> not_empty, "fifo pop while empty")
   `BPC_ASSERT_NEXT(a_tail_last, push_n != 2'd0, mem_ff[wr_ptr_ff - PTR_W'(1)].last, "last result of a tick not marked")

endmodule
